// ===== design/pcd_pkg.sv =====
// Shared types, constants and the period table of the packed pattern cell decoder.
`default_nettype none

package pcd_pkg;

  localparam int unsigned CELLS_DEFAULT = 256;
  localparam int unsigned QDEPTH        = 2;

  localparam logic [7:0] LEAD_EMPTY   = 8'hC0;
  localparam logic [7:0] EFFECT_MASK  = 8'hC0;
  localparam logic [7:0] EFFECT_CODE  = 8'h80;
  localparam logic [6:0] NOTE_MAX     = 7'd36;

  typedef enum logic [1:0] {
    OP_EMPTY  = 2'd0,
    OP_EFFECT = 2'd1,
    OP_NOTE   = 2'd2,
    OP_BAD    = 2'd3
  } op_kind_t;

  // One classified cell on its way to the assembly stage.
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] lead;
    logic [7:0] second;
    logic [7:0] tail;
    logic       last;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_slot_t;

  function automatic logic [11:0] period_lookup(input logic [6:0] note);
    logic [11:0] p;
    case (note)
      7'd1:    p = 12'd856;
      7'd2:    p = 12'd808;
      7'd3:    p = 12'd762;
      7'd4:    p = 12'd720;
      7'd5:    p = 12'd678;
      7'd6:    p = 12'd640;
      7'd7:    p = 12'd604;
      7'd8:    p = 12'd570;
      7'd9:    p = 12'd538;
      7'd10:   p = 12'd508;
      7'd11:   p = 12'd480;
      7'd12:   p = 12'd453;
      7'd13:   p = 12'd428;
      7'd14:   p = 12'd404;
      7'd15:   p = 12'd381;
      7'd16:   p = 12'd360;
      7'd17:   p = 12'd339;
      7'd18:   p = 12'd320;
      7'd19:   p = 12'd302;
      7'd20:   p = 12'd285;
      7'd21:   p = 12'd269;
      7'd22:   p = 12'd254;
      7'd23:   p = 12'd240;
      7'd24:   p = 12'd226;
      7'd25:   p = 12'd214;
      7'd26:   p = 12'd202;
      7'd27:   p = 12'd190;
      7'd28:   p = 12'd180;
      7'd29:   p = 12'd170;
      7'd30:   p = 12'd160;
      7'd31:   p = 12'd151;
      7'd32:   p = 12'd143;
      7'd33:   p = 12'd135;
      7'd34:   p = 12'd127;
      7'd35:   p = 12'd120;
      7'd36:   p = 12'd113;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/pcd_if.sv =====
// Valid/ready channel interfaces for pattern bytes and rebuilt cells.
`default_nettype none

interface pcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       pattern_start;

  modport source (output valid, output data_byte, output pattern_start, input ready);
  modport sink   (input valid, input data_byte, input pattern_start, output ready);
endinterface

interface pcd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cell_word;
  logic        last_cell;
  logic        bad_note;

  modport source (output valid, output cell_word, output last_cell, output bad_note,
                  input ready);
  modport sink   (input valid, input cell_word, input last_cell, input bad_note,
                  output ready);
endinterface

`default_nettype wire

// ===== design/packed_pattern_cell_decoder.sv =====
// Packed pattern cell decoder: top level joining classifier, op queue and assembly.
//
// Usage:
//   in_ch carries one byte of packed pattern data per item, with pattern_start
//   set on the first byte of each pattern. out_ch carries one rebuilt 32-bit
//   cell (p0..p3, big-endian) per item, with last_cell on the final cell of the
//   pattern and bad_note on an aborted pattern.
//   A lead byte of 0xC0 gives an empty cell at once; an effect lead takes one
//   more byte; a note lead takes two more. An over-range note gives an error
//   item on the lead byte and the decoder then drops bytes until a pattern
//   start. After the last cell it also waits for a pattern start.
//   A byte that completes a cell is written into the op queue when it is
//   accepted; the assembly stage then pops the op and registers the cell in
//   the output register, which drives out_ch. Throughput: one byte per cycle,
//   set by one op queue push and one pop per cycle with the output drained.
//   When out_ch stalls, the output register holds its item and the two-entry
//   op queue fills; in_ch.ready drops only when the queue is full.
//   Reset (rst_n low, synchronous) empties the queue and the output register
//   and leaves the decoder waiting for a pattern start.
`default_nettype none

module packed_pattern_cell_decoder #(
  parameter int unsigned CELLS_PER_PATTERN = pcd_pkg::CELLS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pcd_in_if.sink     in_ch,
  pcd_out_if.source  out_ch
);
  import pcd_pkg::*;

  op_slot_t push;
  op_slot_t head;
  logic     q_full;
  logic     pop;
  logic     accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  pcd_front #(
    .CELLS_PER_PATTERN (CELLS_PER_PATTERN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_ch.data_byte),
    .pattern_start (in_ch.pattern_start),
    .push          (push)
  );

  pcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  pcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cell_word (out_ch.cell_word),
    .last_cell (out_ch.last_cell),
    .bad_note  (out_ch.bad_note)
  );

endmodule

`default_nettype wire

// ===== design/pcd_front.sv =====
// Byte classifier: tracks the cell phase, cell count and halt, and issues cell ops.
`default_nettype none

module pcd_front #(
  parameter int unsigned CELLS_PER_PATTERN = pcd_pkg::CELLS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             pattern_start,
  output pcd_pkg::op_slot_t     push
);
  import pcd_pkg::*;

  localparam int unsigned IDX_W = (CELLS_PER_PATTERN > 1) ? $clog2(CELLS_PER_PATTERN) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELLS_PER_PATTERN - 1);

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_EFFECT = 2'd1,
    PH_SECOND = 2'd2,
    PH_THIRD  = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt, phase_v;
  logic [7:0]       lead_r, lead_nxt;
  logic [7:0]       second_r, second_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, idx_v;
  logic             halted_r, halted_nxt, halt_v;
  logic             cell_done;
  logic             idx_last;

  // A pattern start drops any partial cell and restarts the count.
  assign phase_v  = pattern_start ? PH_LEAD : phase_r;
  assign idx_v    = pattern_start ? '0 : idx_r;
  assign halt_v   = pattern_start ? 1'b0 : halted_r;
  assign idx_last = (idx_v == IDX_LAST);

  always_comb begin
    phase_nxt      = phase_r;
    lead_nxt       = lead_r;
    second_nxt     = second_r;
    idx_nxt        = idx_r;
    halted_nxt     = halted_r;
    cell_done      = 1'b0;
    push.valid     = 1'b0;
    push.op.kind   = OP_EMPTY;
    push.op.lead   = lead_r;
    push.op.second = second_r;
    push.op.tail   = data_byte;
    push.op.last   = 1'b0;
    if (accept) begin
      phase_nxt  = phase_v;
      idx_nxt    = idx_v;
      halted_nxt = halt_v;
      if (!halt_v) begin
        unique case (phase_v)
          PH_LEAD: begin
            if (data_byte == LEAD_EMPTY) begin
              push.valid   = 1'b1;
              push.op.kind = OP_EMPTY;
              cell_done    = 1'b1;
            end else if ((data_byte & EFFECT_MASK) == EFFECT_CODE) begin
              lead_nxt  = data_byte;
              phase_nxt = PH_EFFECT;
            end else if (data_byte[7:1] > NOTE_MAX) begin
              // answer at once and halt until the next pattern start
              push.valid   = 1'b1;
              push.op.kind = OP_BAD;
              halted_nxt   = 1'b1;
            end else begin
              lead_nxt  = data_byte;
              phase_nxt = PH_SECOND;
            end
          end
          PH_EFFECT: begin
            push.valid   = 1'b1;
            push.op.kind = OP_EFFECT;
            cell_done    = 1'b1;
          end
          PH_SECOND: begin
            second_nxt = data_byte;
            phase_nxt  = PH_THIRD;
          end
          PH_THIRD: begin
            push.valid   = 1'b1;
            push.op.kind = OP_NOTE;
            cell_done    = 1'b1;
          end
          default: phase_nxt = PH_LEAD;
        endcase
        if (cell_done) begin
          phase_nxt    = PH_LEAD;
          push.op.last = idx_last;
          if (idx_last) begin
            halted_nxt = 1'b1;
            idx_nxt    = '0;
          end else begin
            idx_nxt = IDX_W'(idx_v + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      lead_r   <= '0;
      second_r <= '0;
      idx_r    <= '0;
      halted_r <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
      idx_r    <= idx_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/pcd_queue.sv =====
// Short op queue between the classifier and the cell assembly stage.
`default_nettype none

module pcd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pcd_pkg::op_slot_t  push,
  output logic                    full,
  output pcd_pkg::op_slot_t       head,
  input  wire logic               pop
);
  import pcd_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  op_t              q_mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head.valid = (count_r != '0);
  assign head.op    = q_mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = CNT_W'(count_r + 1'b1);
      2'b01:   count_nxt = CNT_W'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("op queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !full)
    else $error("op pushed into a full queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("op queue count lost a push");

endmodule

`default_nettype wire

// ===== design/pcd_back.sv =====
// Cell assembly: period lookup, cell word build and the output register.
`default_nettype none

module pcd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pcd_pkg::op_slot_t  head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             cell_word,
  output logic                    last_cell,
  output logic                    bad_note
);
  import pcd_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] cell_r, cell_nxt;
  logic        last_r, last_nxt;
  logic        bad_r, bad_nxt;
  logic [11:0] period;

  // Take the next op whenever the output register is free or being drained.
  assign pop    = head.valid && (!out_valid_r || out_ready);
  assign period = period_lookup(head.op.lead[7:1]);

  always_comb begin
    out_valid_nxt = out_valid_r;
    cell_nxt      = cell_r;
    last_nxt      = last_r;
    bad_nxt       = bad_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
      last_nxt      = head.op.last;
      bad_nxt       = 1'b0;
      unique case (head.op.kind)
        OP_EMPTY:  cell_nxt = '0;
        OP_EFFECT: cell_nxt = {16'h0000, 4'h0, head.op.lead[5:2], head.op.tail};
        OP_NOTE:   cell_nxt = {3'b000, head.op.lead[0], period, head.op.second,
                               head.op.tail};
        OP_BAD: begin
          cell_nxt = '0;
          last_nxt = 1'b0;
          bad_nxt  = 1'b1;
        end
        default:   cell_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    cell_r <= cell_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid = out_valid_r;
  assign cell_word = cell_r;
  assign last_cell = last_r;
  assign bad_note  = bad_r;

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (cell_r == '0 && !last_r))
    else $error("error cell carries data");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !pop)
    else $error("op taken while a cell is stalled");

  a_stall_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(cell_r) && $stable(last_r) && $stable(bad_r)))
    else $error("stalled cell changed");

endmodule

`default_nettype wire

// ===== verif/packed_pattern_cell_decoder_tb.sv =====
// Self-checking testbench for the packed pattern cell decoder: byte stream in, rebuilt cells out.
module packed_pattern_cell_decoder_tb;
  import pcd_pkg::*;

  localparam int unsigned CELLS       = 256;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned PHASE_BYTES = 430;

  localparam logic [11:0] NOTE_PERIOD [37] = '{
    0,
    856, 808, 762, 720, 678, 640, 604, 570, 538, 508, 480, 453,
    428, 404, 381, 360, 339, 320, 302, 285, 269, 254, 240, 226,
    214, 202, 190, 180, 170, 160, 151, 143, 135, 127, 120, 113
  };

  typedef enum logic [1:0] {
    AWAIT_LEAD   = 2'd0,
    AWAIT_PARAM  = 2'd1,
    AWAIT_SECOND = 2'd2,
    AWAIT_THIRD  = 2'd3
  } byte_step_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BAD,
    TAIL_CUT
  } tail_t;

  typedef struct packed {
    logic [31:0] cell_word;
    logic        last_cell;
    logic        bad_note;
  } cell_t;

  function automatic op_kind_t lead_kind(input logic [7:0] b);
    if (b == LEAD_EMPTY) return OP_EMPTY;
    if ((b & EFFECT_MASK) == EFFECT_CODE) return OP_EFFECT;
    if (b[7:1] > NOTE_MAX) return OP_BAD;
    return OP_NOTE;
  endfunction

  class cell_decode_board;
    cell_t       expected_cells[$];
    int unsigned errors;
    byte_step_t  step;
    logic [7:0]  lead;
    logic [7:0]  second;
    logic [8:0]  cell_no;
    logic        halted;

    function new();
      errors  = 0;
      step    = AWAIT_LEAD;
      lead    = '0;
      second  = '0;
      cell_no = '0;
      halted  = 1'b1;
    endfunction

    function void finish_cell(input logic [31:0] word);
      cell_t c;
      c.cell_word = word;
      c.last_cell = (cell_no >= CELLS - 1);
      c.bad_note  = 1'b0;
      expected_cells.push_back(c);
      step = AWAIT_LEAD;
      if (c.last_cell) begin
        halted  = 1'b1;
        cell_no = '0;
      end else begin
        cell_no = cell_no + 9'd1;
      end
    endfunction

    function void take_byte(input logic [7:0] b, input logic start);
      cell_t       err;
      logic [6:0]  note;
      logic [11:0] per;
      logic [4:0]  ins;
      if (start) begin
        step    = AWAIT_LEAD;
        cell_no = '0;
        halted  = 1'b0;
      end
      if (halted) return;
      case (step)
        AWAIT_LEAD: begin
          case (lead_kind(b))
            OP_EMPTY: finish_cell(32'h0);
            OP_EFFECT: begin
              lead = b;
              step = AWAIT_PARAM;
            end
            OP_BAD: begin
              err = '{cell_word: 32'h0, last_cell: 1'b0, bad_note: 1'b1};
              expected_cells.push_back(err);
              halted = 1'b1;
              step   = AWAIT_LEAD;
            end
            default: begin
              lead = b;
              step = AWAIT_SECOND;
            end
          endcase
        end
        AWAIT_PARAM: finish_cell({16'h0, 4'h0, lead[5:2], b});
        AWAIT_SECOND: begin
          second = b;
          step   = AWAIT_THIRD;
        end
        default: begin
          note = lead[7:1];
          per  = (note <= NOTE_MAX) ? NOTE_PERIOD[note] : 12'h0;
          ins  = {lead[0], second[7:4]};
          finish_cell({3'b000, ins[4], per[11:8], per[7:0], ins[3:0], second[3:0], b});
        end
      endcase
    endfunction

    function void check_cell(input cell_t got);
      cell_t want;
      if (expected_cells.size() == 0) begin
        if (errors < 10)
          $display("unexpected cell: word %h last %b bad %b",
                   got.cell_word, got.last_cell, got.bad_note);
        errors++;
        return;
      end
      want = expected_cells.pop_front();
      if (got.cell_word !== want.cell_word || got.last_cell !== want.last_cell ||
          got.bad_note !== want.bad_note) begin
        if (errors < 10)
          $display("cell mismatch: expected word %h last %b bad %b, got word %h last %b bad %b",
                   want.cell_word, want.last_cell, want.bad_note,
                   got.cell_word, got.last_cell, got.bad_note);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pcd_in_if  in_ch ();
  pcd_out_if out_ch ();

  packed_pattern_cell_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cell_decode_board board = new();

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned decoded    = 0;
  int unsigned quiet_runs = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Handshakes are judged at the falling edge, where every signal has settled.
  always @(negedge clk) begin : monitor
    cell_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.cell_word = out_ch.cell_word;
        got.last_cell = out_ch.last_cell;
        got.bad_note  = out_ch.bad_note;
        board.check_cell(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_runs = 0;
      else
        quiet_runs++;
      if (quiet_runs >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic drive_byte(input logic [7:0] b, input logic start);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.pattern_start <= start;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    board.take_byte(b, start);
  endtask

  function automatic logic [7:0] make_lead(input op_kind_t kind);
    case (kind)
      OP_EMPTY:  return LEAD_EMPTY;
      OP_EFFECT: return {2'b10, 6'($urandom_range(63))};
      OP_NOTE:   return 8'($urandom_range(8'h49));
      default:   return $urandom_range(1) ? 8'($urandom_range(8'h7F, 8'h4A))
                                          : 8'($urandom_range(8'hFF, 8'hC1));
    endcase
  endfunction

  function automatic op_kind_t pick_kind(input int unsigned empty_w);
    int unsigned r;
    r = $urandom_range(99);
    if (r < empty_w) return OP_EMPTY;
    if (r < empty_w + (100 - empty_w) / 2) return OP_EFFECT;
    return OP_NOTE;
  endfunction

  task automatic send_cell(input op_kind_t kind, input logic start);
    drive_byte(make_lead(kind), start);
    decoded++;
    if (kind == OP_EFFECT || kind == OP_NOTE) begin
      drive_byte(8'($urandom_range(255)), 1'b0);
      decoded++;
    end
    if (kind == OP_NOTE) begin
      drive_byte(8'($urandom_range(255)), 1'b0);
      decoded++;
    end
  endtask

  // Bytes sent while the decoder is halted; they must vanish.
  task automatic send_noise();
    repeat ($urandom_range(3, 1)) drive_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic run_pattern(input int unsigned cells, input int unsigned empty_w,
                             input tail_t tail);
    op_kind_t kind;
    for (int unsigned i = 0; i < cells; i++)
      send_cell(pick_kind(empty_w), i == 0);
    case (tail)
      TAIL_BAD: begin
        send_cell(OP_BAD, cells == 0);
        send_noise();
      end
      TAIL_CUT: begin
        // leave a cell half-built for the next pattern start to drop
        kind = $urandom_range(1) ? OP_EFFECT : OP_NOTE;
        drive_byte(make_lead(kind), cells == 0);
        decoded++;
        if (kind == OP_NOTE && $urandom_range(1)) begin
          drive_byte(8'($urandom_range(255)), 1'b0);
          decoded++;
        end
      end
      default: ;
    endcase
    if (cells >= CELLS) send_noise();
  endtask

  initial begin
    int unsigned target;
    int unsigned pick;
    tail_t       tail;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'h00;
    in_ch.pattern_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: halt after reset, extremes of each cell kind, restart, bad notes
    drive_byte(8'h00, 1'b0);
    drive_byte(LEAD_EMPTY, 1'b0);
    drive_byte(LEAD_EMPTY, 1'b1);
    drive_byte(8'h80, 1'b0);
    drive_byte(8'h00, 1'b0);
    drive_byte(8'hBF, 1'b0);
    drive_byte(8'hFF, 1'b0);
    drive_byte(8'h00, 1'b0);
    drive_byte(8'hFF, 1'b0);
    drive_byte(8'hFF, 1'b0);
    drive_byte(8'h01, 1'b0);
    drive_byte(8'h00, 1'b0);
    drive_byte(8'h00, 1'b0);
    drive_byte(8'h49, 1'b0);
    drive_byte(8'hA5, 1'b0);
    drive_byte(8'h5A, 1'b0);
    drive_byte(8'h02, 1'b0);
    drive_byte(8'h30, 1'b0);
    drive_byte(8'h03, 1'b1);
    drive_byte(8'h12, 1'b0);
    drive_byte(8'h34, 1'b0);
    drive_byte(8'h4A, 1'b0);
    drive_byte(LEAD_EMPTY, 1'b0);
    drive_byte(8'hFF, 1'b1);
    drive_byte(8'h12, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      target = decoded + PHASE_BYTES;
      // a complete pattern, mostly empty cells to keep it short
      if (ph % 2 == 0) run_pattern(CELLS, 60, TAIL_NONE);
      while (decoded < target) begin
        pick = $urandom_range(3);
        tail = (pick == 0) ? TAIL_BAD : (pick == 1) ? TAIL_CUT : TAIL_NONE;
        run_pattern($urandom_range(40, 1), 40, tail);
      end
    end
    in_ch.valid <= 1'b0;

    while (board.expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.expected_cells.size() != 0) begin
      $display("%0d expected cells never arrived", board.expected_cells.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pcd_pkg.sv
design/pcd_if.sv
design/pcd_front.sv
design/pcd_queue.sv
design/pcd_back.sv
design/packed_pattern_cell_decoder.sv
verif/packed_pattern_cell_decoder_tb.sv
